@@ rtl/lmas_pkg.sv @@
// Shared types and constants for the LED matrix animation scanner.
package lmas_pkg;

    localparam int FRAME_WIDTH = 8;
    localparam int CFG_W       = 10;
    localparam int COL_W       = 3;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_SCAN  = 2'd1,
        MODE_FRAME = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PLAY_SCROLL = 2'd0,
        PLAY_FRAMES = 2'd1,
        PLAY_BOUNCE = 2'd2
    } t_play;

    typedef enum logic {
        CFG_LENGTH = 1'b0,
        CFG_PLAY   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             done;
    } t_scan;

endpackage

@@ rtl/lmas_store.sv @@
// Pattern store: column byte memory with wrapped write address and registered read.
module lmas_store #(
    parameter int STORE_DEPTH = 512,
    parameter int AW          = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [8:0]    i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    localparam int XW         = AW + 6;
    localparam int WRAP_STEPS = 6;

    logic [7:0]    mem [STORE_DEPTH];
    logic [7:0]    r_rdata;
    logic [XW-1:0] n_acc;
    logic [AW-1:0] waddr_wrapped;

    always_comb begin
        n_acc = XW'(i_waddr);
        for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
            if (n_acc >= XW'(STORE_DEPTH << k)) begin
                n_acc = n_acc - XW'(STORE_DEPTH << k);
            end
        end
        waddr_wrapped = n_acc[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[waddr_wrapped] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/lmas_seq.sv @@
// Scan sequencer: column counter, frame flag, window position and registers.
module lmas_seq #(
    parameter int STORE_DEPTH = 512,
    parameter int AW          = 9,
    parameter int LW          = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [lmas_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                  i_scan_go,
    input  logic                  i_frame_go,
    output logic [AW-1:0]         o_raddr,
    output lmas_pkg::t_scan       o_scan
);
    import lmas_pkg::*;

    logic [CFG_W-1:0] r_length;
    logic [1:0]       r_play;
    logic [AW-1:0]    r_window, n_window;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_tick, n_tick;
    logic             r_back, n_back;
    logic             ended;
    logic [LW-1:0]    len;
    logic [LW-1:0]    last;
    logic [LW:0]      win_x;
    logic [AW:0]      sum;

    always_comb begin
        len = LW'(r_length);
        if (len < LW'(FRAME_WIDTH)) begin
            len = LW'(FRAME_WIDTH);
        end
        if (len > LW'(STORE_DEPTH)) begin
            len = LW'(STORE_DEPTH);
        end
        last  = len - LW'(FRAME_WIDTH);
        win_x = (LW + 1)'(r_window);
    end

    always_comb begin
        sum = {1'b0, r_window} + (AW + 1)'(r_col);
        if (sum >= (AW + 1)'(STORE_DEPTH)) begin
            sum = sum - (AW + 1)'(STORE_DEPTH);
        end
        o_raddr = sum[AW-1:0];
    end

    always_comb begin
        n_window = r_window;
        n_col    = r_col;
        n_tick   = r_tick;
        n_back   = r_back;
        ended    = 1'b0;
        if (i_frame_go) begin
            n_tick = 1'b1;
        end
        if (i_scan_go) begin
            if (r_col == '0) begin
                n_col = COL_W'(FRAME_WIDTH - 1);
                if (r_tick) begin
                    n_tick = 1'b0;
                    case (r_play)
                        PLAY_SCROLL: begin
                            if (win_x + (LW + 1)'(1) > {1'b0, last}) begin
                                ended = 1'b1;
                            end else begin
                                n_window = r_window + AW'(1);
                            end
                        end
                        PLAY_BOUNCE: begin
                            if (!r_back) begin
                                if (win_x + (LW + 1)'(FRAME_WIDTH) >= {1'b0, len}) begin
                                    n_back   = 1'b1;
                                    n_window = AW'(last);
                                end else begin
                                    n_window = r_window + AW'(FRAME_WIDTH);
                                end
                            end else if (win_x >= (LW + 1)'(FRAME_WIDTH)) begin
                                n_window = r_window - AW'(FRAME_WIDTH);
                            end else begin
                                ended = 1'b1;
                            end
                        end
                        default: begin
                            if (win_x + (LW + 1)'(FRAME_WIDTH) >= {1'b0, len}) begin
                                ended = 1'b1;
                            end else begin
                                n_window = r_window + AW'(FRAME_WIDTH);
                            end
                        end
                    endcase
                    if (ended) begin
                        n_window = '0;
                        n_back   = 1'b0;
                    end
                end
            end else begin
                n_col = r_col - COL_W'(1);
            end
        end
        o_scan.col  = r_col;
        o_scan.done = ended;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= CFG_W'(FRAME_WIDTH);
            r_play   <= PLAY_SCROLL;
            r_window <= '0;
            r_col    <= COL_W'(FRAME_WIDTH - 1);
            r_tick   <= 1'b0;
            r_back   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LENGTH: r_length <= i_cfg_data;
                    CFG_PLAY:   r_play   <= i_cfg_data[1:0];
                    default:    r_play   <= r_play;
                endcase
            end
            r_window <= n_window;
            r_col    <= n_col;
            r_tick   <= n_tick;
            r_back   <= n_back;
        end
    end
endmodule

@@ rtl/led_matrix_animation_scanner.sv @@
// Top level of the LED matrix animation scanner: store read pipeline and output register.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------------
//   input    | in        | i_valid / o_ready  | i_mode, i_address, i_value
//   result   | out       | o_valid / i_ready  | o_column_enable, o_row_lines,
//            |           |                    | o_sequence_done
//   config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One item per cycle while o_ready is high. A scan tick reads the pattern store
// in the cycle it is accepted; the read stage passes its result to the output register.
// Reset clears window and flags, loads the column counter with 7; store is not cleared.
// A stalled result holds in the output register while one more scan item
// waits in the read stage; input ready drops only when both are full.
module led_matrix_animation_scanner #(
    parameter int STORE_DEPTH = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_mode,
    input  logic [8:0]                 i_address,
    input  logic [7:0]                 i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_column_enable,
    output logic [7:0]                 o_row_lines,
    output logic                       o_sequence_done,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [lmas_pkg::CFG_W-1:0] i_cfg_data
);
    import lmas_pkg::*;

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int LW_LO = $clog2(STORE_DEPTH + 1);
    localparam int LW    = (LW_LO > CFG_W) ? LW_LO : CFG_W;

    logic          in_acc;
    logic          scan_go;
    logic          frame_go;
    logic          write_go;
    logic          s1_move;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    t_scan         scan;
    t_scan         r_s1;
    logic          r_s1_valid;
    logic          r_o_valid;
    logic [7:0]    r_o_col;
    logic [7:0]    r_o_rows;
    logic          r_o_done;

    assign in_acc   = i_valid && o_ready;
    assign scan_go  = in_acc && (i_mode == MODE_SCAN);
    assign frame_go = in_acc && (i_mode == MODE_FRAME);
    assign write_go = in_acc && (i_mode == MODE_WRITE);
    assign s1_move  = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready  = !r_s1_valid || s1_move;

    lmas_seq #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW),
        .LW          (LW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_scan_go   (scan_go),
        .i_frame_go  (frame_go),
        .o_raddr     (raddr),
        .o_scan      (scan)
    );

    lmas_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (write_go),
        .i_waddr (i_address),
        .i_wdata (i_value),
        .i_re    (scan_go),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (scan_go) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_go) begin
            r_s1 <= scan;
        end
        if (s1_move) begin
            r_o_col  <= 8'b1 << r_s1.col;
            r_o_rows <= ~rdata;
            r_o_done <= r_s1.done;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_column_enable = r_o_col;
    assign o_row_lines     = r_o_rows;
    assign o_sequence_done = r_o_done;

    a_onehot_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(o_column_enable))
        else $error("column enable not one-hot");

    a_done_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sequence_done) |-> o_column_enable[0])
        else $error("sequence done off column zero");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_ready)
        else $error("input stalled with empty read stage");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stalled read stage lost its item");
endmodule
